@@ design/lru_page_fault_tracker_assert.svh @@
// Assertion macros for the LRU page fault tracker.
// Used by the top level only; defining ASSERT_OFF compiles them away.
`ifndef LRU_PAGE_FAULT_TRACKER_ASSERT_SVH
`define LRU_PAGE_FAULT_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define LPFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpft assertion failed");

// Next-cycle implication, checked outside reset.
`define LPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpft assertion failed");

`else

`define LPFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/lpft_pkg.sv @@
// Shared constants and types for the LRU page fault tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpft_pkg;

  localparam int FRAME_DEPTH_DEF = 16;
  localparam int PAGE_WIDTH_DEF  = 16;

  // Fixed port widths
  localparam int PAGE_NUM_W = 16;
  localparam int CAP_W      = 5;
  localparam int FAULT_W    = 32;

  localparam logic [CAP_W-1:0]   CAP_RST   = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

  // Per-cell control from the top level
  typedef struct packed {
    logic load;   // a reference is transferred this cycle
    logic valid;  // cell holds a resident page for this reference
  } lpft_cell_ctl_t;

endpackage

`default_nettype wire

@@ design/lpft_cell.sv @@
// One frame of the recency stack: holds a page, compares it against the
// reference and takes its upstream neighbor's page on a shift. Uses lpft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpft_cell #(
  parameter int PAGE_WIDTH = lpft_pkg::PAGE_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire lpft_pkg::lpft_cell_ctl_t ctl,
  input  wire  [PAGE_WIDTH-1:0]       ref_page,
  input  wire  [PAGE_WIDTH-1:0]       prev_page,
  input  wire                         found_in,
  output logic [PAGE_WIDTH-1:0]       page_q,
  output logic                        found_out
);

  logic [PAGE_WIDTH-1:0] page_r;
  logic [PAGE_WIDTH-1:0] page_nxt;
  logic                  match;

  // Compare the resident page against the reference
  assign match     = ctl.valid && (page_r == ref_page);
  assign found_out = found_in || match;

  // Shift from the more recent neighbor up to and including the hit frame
  always_comb begin
    page_nxt = page_r;
    if (ctl.load && !found_in) begin
      page_nxt = prev_page;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign page_q = page_r;

endmodule

`default_nettype wire

@@ design/lru_page_fault_tracker.sv @@
// LRU page fault tracker: a chain of frame cells, most recent first.
// The result strobe follows start in the next cycle; one reference is taken
// per cycle, set by the compare-and-shift pass through the cell chain.
// busy stays low; results cannot be stalled. Synchronous active-low reset
// empties the set, clears the fault count and sets capacity to 16; no
// clearing pass. Uses lpft_pkg, lpft_cell and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "lru_page_fault_tracker_assert.svh"

module lru_page_fault_tracker #(
  parameter int FRAME_DEPTH = lpft_pkg::FRAME_DEPTH_DEF,
  parameter int PAGE_WIDTH  = lpft_pkg::PAGE_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [lpft_pkg::PAGE_NUM_W-1:0]  in_page_number,
  input  wire                              in_restart,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [lpft_pkg::FAULT_W-1:0]     out_fault_count,
  input  wire                              cfg_we,
  input  wire  [lpft_pkg::CAP_W-1:0]       cfg_wdata
);

  localparam int IW  = lpft_pkg::PAGE_NUM_W;
  localparam int CW  = $clog2(FRAME_DEPTH + 1);
  localparam int CXW = (CW > lpft_pkg::CAP_W) ? CW : lpft_pkg::CAP_W;

  logic [lpft_pkg::CAP_W-1:0]   cap_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [lpft_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic                         valid_r;
  logic                         hit_r;

  logic                  accept;
  logic [PAGE_WIDTH-1:0] ref_page;
  logic [CXW-1:0]        cap_x, cap_eff, base_x, keep_x;
  logic [CW-1:0]         base;
  logic [lpft_pkg::FAULT_W-1:0] fault_base;
  logic                  hit_w;

  logic [PAGE_WIDTH-1:0] page_q [FRAME_DEPTH];
  logic                  found  [FRAME_DEPTH+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Keep the low page bits, zero-extend if the stack is wider
  generate
    if (PAGE_WIDTH <= IW) begin : g_page_trunc
      assign ref_page = in_page_number[PAGE_WIDTH-1:0];
    end else begin : g_page_ext
      assign ref_page = {{(PAGE_WIDTH-IW){1'b0}}, in_page_number};
    end
  endgenerate

  // Cell chain, most recent at index zero
  assign found[0] = 1'b0;
  generate
    for (genvar i = 0; i < FRAME_DEPTH; i++) begin : g_cell
      lpft_pkg::lpft_cell_ctl_t ctl;
      logic [PAGE_WIDTH-1:0]    prev;
      always_comb begin
        ctl.load  = accept;
        ctl.valid = !in_restart && (count_r > CW'(i));
      end
      if (i == 0) begin : g_head
        assign prev = ref_page;
      end else begin : g_link
        assign prev = page_q[i-1];
      end
      lpft_cell #(.PAGE_WIDTH(PAGE_WIDTH)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .ref_page  (ref_page),
        .prev_page (prev),
        .found_in  (found[i]),
        .page_q    (page_q[i]),
        .found_out (found[i+1])
      );
    end
  endgenerate

  assign hit_w = found[FRAME_DEPTH];

  // Clamp capacity to one through the built depth
  always_comb begin
    cap_x = CXW'(cap_r);
    if (cap_x == '0) begin
      cap_eff = CXW'(1);
    end else if (cap_x > CXW'(FRAME_DEPTH)) begin
      cap_eff = CXW'(FRAME_DEPTH);
    end else begin
      cap_eff = cap_x;
    end
  end

  // Next occupancy and fault count; eviction is truncation at the LRU end
  always_comb begin
    base       = in_restart ? '0 : count_r;
    fault_base = in_restart ? '0 : fault_r;
    base_x     = CXW'(base);
    keep_x     = (base_x >= cap_eff) ? (cap_eff - CXW'(1)) : base_x;
    count_nxt  = count_r;
    fault_nxt  = fault_r;
    if (accept) begin
      if (hit_w) begin
        count_nxt = base;
        fault_nxt = fault_base;
      end else begin
        count_nxt = CW'(keep_x + CXW'(1));
        fault_nxt = (fault_base == lpft_pkg::FAULT_MAX) ? fault_base
                                                        : fault_base + 1'b1;
      end
    end
  end

  // Hold state, advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= lpft_pkg::CAP_RST;
      count_r <= '0;
      fault_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      fault_r <= fault_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r <= hit_w;
    end
  end

  assign out_valid       = valid_r;
  assign out_hit         = hit_r;
  assign out_fault_count = fault_r;

  // Checks
  `LPFT_ASSERT_NEXT(a_strobe, clk, rst_n, accept, out_valid)
  `LPFT_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(FRAME_DEPTH))
  `LPFT_ASSERT_NEXT(a_restart_fault, clk, rst_n, accept && in_restart, out_fault_count == 32'd1)
  `LPFT_ASSERT_NEXT(a_hit_keeps, clk, rst_n, accept && !in_restart && hit_w, count_r == $past(count_r))

endmodule

`default_nettype wire
